FILE: sv/utf8u_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8u_pkg: shared types and constants of the UTF-8 transcoder
// Decoder state, result item layout, error codes and register indexes.
// ----------------------------------------------------------------------------
package utf8u_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int CAP_BITS    = 16;
  localparam int SUM_BITS    = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
  localparam int CODE_BITS   = 21;
  localparam int WRITTEN_BITS = 16;
  localparam int ERR_BITS    = 3;

  localparam int IN_TDATA_BITS   = 8;
  localparam int OUT_TDATA_BITS  = ((CODE_BITS + WRITTEN_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS  = ERR_BITS + 1;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 16;

  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_DEPTH    = 1 << FIFO_PTR_BITS;
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  typedef logic [ERR_BITS-1:0] err_t;
  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_OVERLONG = 3'd1;
  localparam err_t ERR_TRUNC    = 3'd2;
  localparam err_t ERR_BAD_LEN  = 3'd3;
  localparam err_t ERR_BOM      = 3'd4;
  localparam err_t ERR_OVERFLOW = 3'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UTF16_MODE   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_CAPACITY = 8'd1;

  typedef struct packed {
    logic [CODE_BITS-1:0]  partial;
    logic [1:0]            bytes_left;
    logic [2:0]            seq_len;
    logic [COUNT_BITS-1:0] unit_count;
    logic                  discarding;
  } dec_state_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]    code_unit;
    err_t                    error_code;
    logic                    run_last;
    logic                    string_end;
    logic [WRITTEN_BITS-1:0] units_written;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_pair;
  } fifo_stat_t;

  // Low bits of the unit count, zero-extended when the count is narrow.
  function automatic logic [WRITTEN_BITS-1:0] to_written(input logic [COUNT_BITS-1:0] cnt);
    logic [COUNT_BITS+WRITTEN_BITS-1:0] wide;
    wide = {{WRITTEN_BITS{1'b0}}, cnt};
    return wide[WRITTEN_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/utf8u_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8u_decode: single-byte decode step
// Folds one byte into the sequence state and forms up to two result items.
// ----------------------------------------------------------------------------
module utf8u_decode (
  input  utf8u_pkg::dec_state_t             st,
  input  logic [7:0]                        byte_in,
  input  logic                              last_in,
  input  logic                              utf16_mode,
  input  logic [utf8u_pkg::CAP_BITS-1:0]    capacity,
  output utf8u_pkg::dec_state_t             st_nxt,
  output logic [1:0]                        n_res,
  output utf8u_pkg::result_t                res0,
  output utf8u_pkg::result_t                res1
);
  import utf8u_pkg::*;

  logic                  do_emit;
  logic                  do_err;
  err_t                  err;
  logic [CODE_BITS-1:0]  cp;
  logic [CODE_BITS-1:0]  acc;
  logic [1:0]            bl_dec;
  logic [CODE_BITS-1:0]  least;
  logic                  need2;
  logic [SUM_BITS-1:0]   sum;
  logic [CODE_BITS-1:0]  v;
  logic [COUNT_BITS-1:0] uc_inc;

  always_comb begin
    st_nxt  = st;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    do_emit = 1'b0;
    do_err  = 1'b0;
    err     = ERR_NONE;
    cp      = '0;
    acc     = {st.partial[CODE_BITS-7:0], byte_in[5:0]};
    bl_dec  = st.bytes_left - 2'd1;
    case (st.seq_len)
      3'd2:    least = 21'h80;
      3'd3:    least = 21'h800;
      default: least = 21'h10000;
    endcase

    if (st.discarding) begin
      // drop bytes up to the end of the string
      if (last_in) begin
        st_nxt.discarding = 1'b0;
      end
    end else if (st.bytes_left == 2'd0) begin
      if (byte_in < 8'hC0) begin
        do_emit = 1'b1;
        cp      = {13'd0, byte_in};
      end else if (byte_in < 8'hF8) begin
        if (byte_in < 8'hE0) begin
          st_nxt.seq_len    = 3'd2;
          st_nxt.bytes_left = 2'd1;
          st_nxt.partial    = {16'd0, byte_in[4:0]};
        end else if (byte_in < 8'hF0) begin
          st_nxt.seq_len    = 3'd3;
          st_nxt.bytes_left = 2'd2;
          st_nxt.partial    = {17'd0, byte_in[3:0]};
        end else begin
          st_nxt.seq_len    = 3'd4;
          st_nxt.bytes_left = 2'd3;
          st_nxt.partial    = {18'd0, byte_in[2:0]};
        end
        if (last_in) begin
          do_err = 1'b1;
          err    = ERR_TRUNC;
        end
      end else if (byte_in < 8'hFE) begin
        do_err = 1'b1;
        err    = ERR_BAD_LEN;
      end else begin
        do_err = 1'b1;
        err    = ERR_BOM;
      end
    end else begin
      st_nxt.partial    = acc;
      st_nxt.bytes_left = bl_dec;
      if (bl_dec != 2'd0) begin
        if (last_in) begin
          do_err = 1'b1;
          err    = ERR_TRUNC;
        end
      end else begin
        st_nxt.partial = '0;
        st_nxt.seq_len = 3'd0;
        if (acc < least) begin
          do_err = 1'b1;
          err    = ERR_OVERLONG;
        end else begin
          do_emit = 1'b1;
          cp      = acc;
        end
      end
    end

    need2  = utf16_mode && (cp >= 21'h10000);
    sum    = SUM_BITS'(st.unit_count) + (need2 ? SUM_BITS'(2) : SUM_BITS'(1));
    v      = cp - 21'h10000;
    uc_inc = st.unit_count + COUNT_BITS'(1);

    if (do_emit) begin
      if (sum > SUM_BITS'(capacity)) begin
        do_err = 1'b1;
        err    = ERR_OVERFLOW;
      end else begin
        if (need2) begin
          res0.code_unit     = {10'd0, v[20:10]} + 21'hD800;
          res0.error_code    = ERR_NONE;
          res0.run_last      = 1'b0;
          res0.string_end    = 1'b0;
          res0.units_written = to_written(uc_inc);
          res1.code_unit     = 21'hDC00 | {11'd0, v[9:0]};
          res1.error_code    = ERR_NONE;
          res1.run_last      = 1'b1;
          res1.string_end    = last_in;
          res1.units_written = to_written(sum[COUNT_BITS-1:0]);
          n_res              = 2'd2;
        end else begin
          res0.code_unit     = cp;
          res0.error_code    = ERR_NONE;
          res0.run_last      = 1'b1;
          res0.string_end    = last_in;
          res0.units_written = to_written(uc_inc);
          n_res              = 2'd1;
        end
        st_nxt.unit_count = last_in ? '0 : sum[COUNT_BITS-1:0];
      end
    end

    if (do_err) begin
      res0.code_unit     = '0;
      res0.error_code    = err;
      res0.run_last      = 1'b1;
      res0.string_end    = 1'b1;
      res0.units_written = to_written(st.unit_count);
      n_res              = 2'd1;
      st_nxt.partial     = '0;
      st_nxt.bytes_left  = 2'd0;
      st_nxt.seq_len     = 3'd0;
      st_nxt.unit_count  = '0;
      st_nxt.discarding  = !last_in;
    end
  end

endmodule
`default_nettype wire

FILE: sv/utf8u_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8u_res_fifo: result queue
// Four-entry queue that takes up to two result items a cycle, gives one.
// ----------------------------------------------------------------------------
module utf8u_res_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  utf8u_pkg::result_t    push0,
  input  utf8u_pkg::result_t    push1,
  input  logic                  pop,
  output utf8u_pkg::result_t    head,
  output utf8u_pkg::fifo_stat_t stat
);
  import utf8u_pkg::*;

  result_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0] cnt_r;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_nxt;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_PTR_BITS'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_BITS'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_BITS'(pop);
  assign cnt_nxt    = cnt_r + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head               = mem_r[rd_ptr_r];
  assign stat.not_empty     = (cnt_r != '0);
  assign stat.room_for_pair = (cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> (cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH - 2)))
    else $error("push without room for a pair");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

FILE: sv/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: UTF-8 byte stream to UTF-16 or UTF-32 units
// Decodes one byte per item, emits code units with status and counts.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | content
//  in_     | in  | in_tvalid/in_tready | tdata: in_byte; tlast: in_last
//  out_    | out | out_tvalid/tready   | tdata: code_unit, units_written;
//          |     |                     | tuser: error_code, run_last; tlast: string_end
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One byte is accepted per cycle while in_tready is high; its results enter
// the result queue at that edge and show on out_ behind earlier queued items.
// A surrogate-pair byte yields two units, one per cycle while out_tready is high.
// in_tready drops while the four-entry result queue lacks room for a pair.
// Reset is synchronous and clears the sequence state, counts and queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [utf8u_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // [7:0] in_byte
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [utf8u_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // [20:0] code_unit,
                                                            // [36:21] units_written
  output logic [utf8u_pkg::OUT_TUSER_BITS-1:0]  out_tuser,  // [2:0] error_code,
                                                            // [3] run_last
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [utf8u_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [utf8u_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import utf8u_pkg::*;

  dec_state_t           st_r;
  dec_state_t           st_nxt;
  logic                 utf16_mode_r;
  logic [CAP_BITS-1:0]  capacity_r;
  logic [1:0]           n_res;
  result_t              res0;
  result_t              res1;
  result_t              head;
  fifo_stat_t           fstat;
  logic                 in_fire;
  logic                 pop;

  assign in_tready = fstat.room_for_pair;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_mode_r <= 1'b1;
      capacity_r   <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UTF16_MODE:   utf16_mode_r <= cfg_data[0];
        REG_OUT_CAPACITY: capacity_r   <= cfg_data[CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  utf8u_decode u_decode (
    .st         (st_r),
    .byte_in    (in_tdata[7:0]),
    .last_in    (in_tlast),
    .utf16_mode (utf16_mode_r),
    .capacity   (capacity_r),
    .st_nxt     (st_nxt),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  utf8u_res_fifo u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (in_fire ? n_res : 2'd0),
    .push0  (res0),
    .push1  (res1),
    .pop    (pop),
    .head   (head),
    .stat   (fstat)
  );

  assign out_tvalid = fstat.not_empty;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {{(OUT_TDATA_BITS - CODE_BITS - WRITTEN_BITS){1'b0}},
                       head.units_written, head.code_unit};
  assign out_tuser  = {head.run_last, head.error_code};
  assign out_tlast  = head.string_end;

  a_err_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (head.error_code != ERR_NONE)) |-> (head.code_unit == '0))
    else $error("error item carries a nonzero code unit");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && head.string_end) |-> head.run_last)
    else $error("string end without run_last");

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (st_r.unit_count == '0) && (st_r.bytes_left == 2'd0))
    else $error("string state not cleared after last byte");

endmodule
`default_nettype wire
